@@ hdl/ssh_banner_packet_classifier_top_defines.svh @@
// ----------------------------------------------------------------------------
// SSH banner classifier assertion macros
// Shared concurrent assertion forms for the classifier top level.
// ----------------------------------------------------------------------------
`ifndef SSH_BANNER_PACKET_CLASSIFIER_TOP_DEFINES_SVH
`define SSH_BANNER_PACKET_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SBPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SBPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sbpc_pkg.sv @@
// ----------------------------------------------------------------------------
// SSH banner classifier package
// Frame layout constants, verdict codes, shared types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sbpc_pkg;

    localparam int POSITION_BITS_DEF = 8;

    // frame layout, in bytes: Ethernet fields from the frame start, IP and TCP fields from their header start
    localparam int ETYPE_POS_HI  = 12;
    localparam int ETH_LEN       = 14;
    localparam int V4_PROTO_OFS  = 9;
    localparam int V4_SRC_OFS    = 12;
    localparam int V4_DST_OFS    = 16;
    localparam int V4_ADDR_END   = 20;
    localparam int V4_HDR_MIN    = 20;
    localparam int V6_PROTO_OFS  = 6;
    localparam int V6_SRC_OFS    = 8;
    localparam int V6_DST_OFS    = 24;
    localparam int V6_HDR_LEN    = 40;
    localparam int PORT_LEN      = 4;
    localparam int TCP_OFF_POS   = 12;
    localparam int TCP_HDR_LEN   = 20;
    localparam int WINDOW_LEN    = 8;
    localparam int MIN_WORDS     = 5;

    localparam logic [15:0] ETYPE_V4  = 16'h0800;
    localparam logic [15:0] ETYPE_V6  = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;

    localparam logic [63:0] SIG_RESET = 64'h5353482D322E302D;

    typedef logic [2:0] t_verdict;

    localparam t_verdict VERDICT_MATCH     = 3'd0;
    localparam t_verdict VERDICT_NOT_IP    = 3'd1;
    localparam t_verdict VERDICT_NOT_TCP   = 3'd2;
    localparam t_verdict VERDICT_SHORT     = 3'd3;
    localparam t_verdict VERDICT_MISMATCH  = 3'd4;
    localparam t_verdict VERDICT_MALFORMED = 3'd5;

    localparam logic [2:0] IPVER_NONE = 3'd0;
    localparam logic [2:0] IPVER_4    = 3'd4;
    localparam logic [2:0] IPVER_6    = 3'd6;

    typedef struct packed {
        logic [15:0]  ether_kind;
        logic [3:0]   ihl;
        logic [7:0]   proto;
        logic [3:0]   tcp_off;
        logic [31:0]  ports;
        logic [127:0] src_addr;
        logic [127:0] dst_addr;
        logic [63:0]  payload;
    } t_frame;

    typedef struct packed {
        t_verdict    verdict;
        logic [2:0]  ip_version;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [63:0] source_addr_high;
        logic [63:0] source_addr_low;
        logic [63:0] dest_addr_high;
        logic [63:0] dest_addr_low;
    } t_result;

    // first byte of the transport header
    function automatic logic [7:0] l4_start(input logic [15:0] ether_kind,
                                            input logic [3:0]  ihl);
        logic [7:0] v4_start;
        v4_start = 8'(ETH_LEN) + {2'b00, ihl, 2'b00};
        return (ether_kind == ETYPE_V4) ? v4_start : 8'(ETH_LEN + V6_HDR_LEN);
    endfunction

endpackage

`default_nettype wire

@@ hdl/sbpc_if.sv @@
// ----------------------------------------------------------------------------
// SSH banner classifier channels
// Byte input channel and verdict output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface sbpc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [2:0]  ip_version;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;

    modport source (output valid, output verdict, output ip_version, output source_port,
                    output destination_port, output source_addr_high,
                    output source_addr_low, output dest_addr_high, output dest_addr_low,
                    input ready);
    modport sink   (input valid, input verdict, input ip_version, input source_port,
                    input destination_port, input source_addr_high,
                    input source_addr_low, input dest_addr_high, input dest_addr_low,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/sbpc_capture.sv @@
// ----------------------------------------------------------------------------
// SSH banner classifier field capture
// Tracks the byte position and captures header fields and payload window.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpc_capture
    import sbpc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_advance,
    input  wire logic [7:0]               i_byte,
    input  wire logic                     i_last,
    output logic      [POSITION_BITS-1:0] o_pos,
    output t_frame                        o_frame
);

    localparam int LW = POSITION_BITS + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    t_frame                   r_frame;
    t_frame                   n_frame;

    logic          w_v4;
    logic          w_v6;
    logic          w_l4_on;
    logic [LW-1:0] w_p;
    logic [LW-1:0] w_l4;
    logic [LW-1:0] w_po;

    always_comb begin
        w_p     = LW'(r_pos);
        n_frame = r_frame;

        if (r_pos == POSITION_BITS'(ETYPE_POS_HI)) begin
            n_frame.ether_kind = {i_byte, 8'h00};
        end else if (r_pos == POSITION_BITS'(ETYPE_POS_HI + 1)) begin
            n_frame.ether_kind = r_frame.ether_kind | {8'h00, i_byte};
        end

        w_v4 = (r_frame.ether_kind == ETYPE_V4) && (w_p >= LW'(ETH_LEN));
        w_v6 = (r_frame.ether_kind == ETYPE_V6) && (w_p >= LW'(ETH_LEN));

        if (w_v4) begin
            if (w_p == LW'(ETH_LEN)) begin
                n_frame.ihl = i_byte[3:0];
            end
            if (w_p == LW'(ETH_LEN + V4_PROTO_OFS)) begin
                n_frame.proto = i_byte;
            end
            if (w_p >= LW'(ETH_LEN + V4_SRC_OFS) && w_p < LW'(ETH_LEN + V4_DST_OFS)) begin
                n_frame.src_addr = {r_frame.src_addr[119:0], i_byte};
            end
            if (w_p >= LW'(ETH_LEN + V4_DST_OFS) && w_p < LW'(ETH_LEN + V4_ADDR_END)) begin
                n_frame.dst_addr = {r_frame.dst_addr[119:0], i_byte};
            end
        end

        if (w_v6) begin
            if (w_p == LW'(ETH_LEN + V6_PROTO_OFS)) begin
                n_frame.proto = i_byte;
            end
            if (w_p >= LW'(ETH_LEN + V6_SRC_OFS) && w_p < LW'(ETH_LEN + V6_DST_OFS)) begin
                n_frame.src_addr = {r_frame.src_addr[119:0], i_byte};
            end
            if (w_p >= LW'(ETH_LEN + V6_DST_OFS) && w_p < LW'(ETH_LEN + V6_HDR_LEN)) begin
                n_frame.dst_addr = {r_frame.dst_addr[119:0], i_byte};
            end
        end

        // transport fields only once the IPv4 length nibble is in
        w_l4_on = (w_v4 && (w_p > LW'(ETH_LEN))) || w_v6;
        w_l4    = LW'(l4_start(r_frame.ether_kind, r_frame.ihl));
        w_po    = w_l4 + LW'({r_frame.tcp_off, 2'b00});

        if (w_l4_on) begin
            if (w_p >= w_l4 && w_p < w_l4 + LW'(PORT_LEN)) begin
                n_frame.ports = {r_frame.ports[23:0], i_byte};
            end
            if (w_p == w_l4 + LW'(TCP_OFF_POS)) begin
                n_frame.tcp_off = i_byte[7:4];
            end
            if (w_p > w_l4 + LW'(TCP_OFF_POS) && w_p >= w_po
                    && w_p < w_po + LW'(WINDOW_LEN)) begin
                n_frame.payload = {r_frame.payload[55:0], i_byte};
            end
        end

        // saturate the position on long frames
        n_pos = (r_pos != POS_MAX) ? r_pos + POSITION_BITS'(1) : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_frame <= '0;
        end else if (i_advance) begin
            if (i_last) begin
                r_pos   <= '0;
                r_frame <= '0;
            end else begin
                r_pos   <= n_pos;
                r_frame <= n_frame;
            end
        end
    end

    assign o_pos   = r_pos;
    assign o_frame = n_frame;

endmodule

`default_nettype wire

@@ hdl/sbpc_verdict.sv @@
// ----------------------------------------------------------------------------
// SSH banner classifier verdict
// Classifies a finished frame and selects the reported fields.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpc_verdict
    import sbpc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic [POSITION_BITS-1:0] i_pos,
    input  wire t_frame                   i_frame,
    input  wire logic [63:0]              i_signature,
    output t_result                       o_result
);

    localparam int LW = POSITION_BITS + 1;

    logic          w_is_v4;
    logic          w_is_v6;
    logic [LW-1:0] w_len;
    logic [LW-1:0] w_l4;
    logic [LW-1:0] w_po;
    logic [LW-1:0] w_ip_min;
    t_verdict      w_verdict;

    always_comb begin
        w_is_v4  = (i_frame.ether_kind == ETYPE_V4);
        w_is_v6  = (i_frame.ether_kind == ETYPE_V6);
        w_len    = LW'(i_pos) + LW'(1);
        w_l4     = LW'(l4_start(i_frame.ether_kind, i_frame.ihl));
        w_po     = w_l4 + LW'({i_frame.tcp_off, 2'b00});
        w_ip_min = w_is_v4 ? LW'(ETH_LEN + V4_HDR_MIN) : LW'(ETH_LEN + V6_HDR_LEN);

        priority if (w_len < LW'(ETH_LEN)) begin
            w_verdict = VERDICT_SHORT;
        end else if (!w_is_v4 && !w_is_v6) begin
            w_verdict = VERDICT_NOT_IP;
        end else if (w_len < w_ip_min) begin
            w_verdict = VERDICT_SHORT;
        end else if (i_frame.proto != PROTO_TCP) begin
            w_verdict = VERDICT_NOT_TCP;
        end else if (w_is_v4 && i_frame.ihl < 4'(MIN_WORDS)) begin
            w_verdict = VERDICT_MALFORMED;
        end else if (w_len < w_l4 + LW'(TCP_HDR_LEN)) begin
            w_verdict = VERDICT_SHORT;
        end else if (i_frame.tcp_off < 4'(MIN_WORDS)) begin
            w_verdict = VERDICT_MALFORMED;
        end else if (w_po + LW'(WINDOW_LEN) > w_len) begin
            w_verdict = VERDICT_SHORT;
        end else if (i_frame.payload != i_signature) begin
            w_verdict = VERDICT_MISMATCH;
        end else begin
            w_verdict = VERDICT_MATCH;
        end

        o_result            = '0;
        o_result.verdict    = w_verdict;
        o_result.ip_version = w_is_v4 ? IPVER_4 : (w_is_v6 ? IPVER_6 : IPVER_NONE);
        if (w_len < LW'(ETH_LEN)) begin
            o_result.ip_version = IPVER_NONE;
        end
        // report addresses and ports on a match only
        if (w_verdict == VERDICT_MATCH) begin
            o_result.source_port      = i_frame.ports[31:16];
            o_result.destination_port = i_frame.ports[15:0];
            o_result.source_addr_high = i_frame.src_addr[127:64];
            o_result.source_addr_low  = i_frame.src_addr[63:0];
            o_result.dest_addr_high   = i_frame.dst_addr[127:64];
            o_result.dest_addr_low    = i_frame.dst_addr[63:0];
        end
    end

endmodule

`default_nettype wire

@@ hdl/ssh_banner_packet_classifier_top.sv @@
// ----------------------------------------------------------------------------
// SSH banner packet classifier
// Parses Ethernet/IP/TCP headers and matches the payload against a signature.
// ----------------------------------------------------------------------------
// Frames enter one byte per word from the destination MAC onward, and the
// block takes one word every clock unless a last byte waits on an unread
// verdict. A word is held in an input register; the field capture logic then
// updates the frame state from it and, on the last byte, the classifier loads
// the verdict into the output register. The output register decouples the
// two sides: bytes keep flowing while a verdict waits, and the input stalls
// only when a second last byte meets an unread verdict. The user must write
// the signature register only while idle; the block does not enforce it.
`default_nettype none

`include "ssh_banner_packet_classifier_top_defines.svh"

module ssh_banner_packet_classifier_top
    import sbpc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [63:0] i_cfg_wr_data,
    sbpc_in_if.sink          i_in,
    sbpc_out_if.source       o_out
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [63:0] r_signature;
    logic        r_out_valid;
    t_result     r_out;

    logic                     w_out_free;
    logic                     w_advance;
    logic                     w_in_ready;
    logic [POSITION_BITS-1:0] w_pos;
    t_frame                   w_frame;
    t_result                  w_result;

    assign w_out_free = !r_out_valid || o_out.ready;
    // a last word needs room in the output register, other words never wait
    assign w_advance  = r_in_valid && (!r_in_last || w_out_free);
    assign w_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_byte <= i_in.packet_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signature <= SIG_RESET;
        end else if (i_cfg_wr_en) begin
            r_signature <= i_cfg_wr_data;
        end
    end

    sbpc_capture #(
        .POSITION_BITS(POSITION_BITS)
    ) u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(w_advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_pos    (w_pos),
        .o_frame  (w_frame)
    );

    sbpc_verdict #(
        .POSITION_BITS(POSITION_BITS)
    ) u_verdict (
        .i_pos      (w_pos),
        .i_frame    (w_frame),
        .i_signature(r_signature),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign i_in.ready             = w_in_ready;
    assign o_out.valid            = r_out_valid;
    assign o_out.verdict          = r_out.verdict;
    assign o_out.ip_version       = r_out.ip_version;
    assign o_out.source_port      = r_out.source_port;
    assign o_out.destination_port = r_out.destination_port;
    assign o_out.source_addr_high = r_out.source_addr_high;
    assign o_out.source_addr_low  = r_out.source_addr_low;
    assign o_out.dest_addr_high   = r_out.dest_addr_high;
    assign o_out.dest_addr_low    = r_out.dest_addr_low;

    `SBPC_ASSERT_NXT(a_last_loads_out, i_clk, i_rst_n, w_advance && r_in_last, r_out_valid && w_pos == '0, "last word did not load a verdict and restart the frame")
    `SBPC_ASSERT_IMP(a_fields_zero, i_clk, i_rst_n, r_out_valid && r_out.verdict != VERDICT_MATCH, r_out.source_port == '0 && r_out.destination_port == '0 && r_out.source_addr_high == '0 && r_out.source_addr_low == '0 && r_out.dest_addr_high == '0 && r_out.dest_addr_low == '0, "non-match verdict carries address or port data")
    `SBPC_ASSERT_IMP(a_ip_version, i_clk, i_rst_n, r_out_valid && (r_out.verdict == VERDICT_MATCH || r_out.verdict == VERDICT_MISMATCH || r_out.verdict == VERDICT_NOT_TCP || r_out.verdict == VERDICT_MALFORMED), r_out.ip_version == IPVER_4 || r_out.ip_version == IPVER_6, "IP verdict without IP version")
    `SBPC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_out.ready, !(w_advance && r_in_last), "verdict overwritten while stalled")

endmodule

`default_nettype wire
